// ===== design/ttip_pkg.sv =====
`timescale 1ns / 1ps

package ttip_pkg;

    // Widths of the text, the radix and the result fields
    localparam int CHAR_W       = 8;
    localparam int BASE_W       = 6;
    localparam int DIGIT_W      = 6;
    localparam int VALUE_WIDTH  = 32;
    localparam int LENGTH_WIDTH = 16;

    // Signed limits as magnitudes
    localparam logic [VALUE_WIDTH-1:0] POS_LIM = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] NEG_LIM = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // Radix codes
    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_DEC;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'd88;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'd90;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'd120;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'd122;
    localparam logic [CHAR_W-1:0] UPPER_OFS = CH_UA - 8'd10;
    localparam logic [CHAR_W-1:0] LOWER_OFS = CH_LA - 8'd10;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_COUNT,
        OP_SIGN,
        OP_ZERO_PREFIX,
        OP_START_DIGIT,
        OP_HEX,
        OP_DIGIT,
        OP_FINISH
    } op_t;

    // Controller to datapath
    typedef struct packed {
        op_t op;
    } cmd_t;

    // Datapath to controller: class of the current character
    typedef struct packed {
        logic is_white;
        logic is_sign;
        logic is_zero_char;
        logic is_hex_mark;
        logic cfg_invalid;
        logic prefix_ok;
        logic start_digit_ok;
        logic digit_ok;
    } status_t;

    // Per-radix overflow limit
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] cut;
        logic [DIGIT_W-1:0]     last;
    } cutoff_t;

    function automatic cutoff_t cutoff_lookup(input logic [BASE_W-1:0] base, input logic neg);
        cutoff_t r;
        r = '{cut: '0, last: '0};
        case (base)
            6'd2:  r = neg ? '{NEG_LIM / 2, DIGIT_W'(NEG_LIM % 2)}
                           : '{POS_LIM / 2, DIGIT_W'(POS_LIM % 2)};
            6'd3:  r = neg ? '{NEG_LIM / 3, DIGIT_W'(NEG_LIM % 3)}
                           : '{POS_LIM / 3, DIGIT_W'(POS_LIM % 3)};
            6'd4:  r = neg ? '{NEG_LIM / 4, DIGIT_W'(NEG_LIM % 4)}
                           : '{POS_LIM / 4, DIGIT_W'(POS_LIM % 4)};
            6'd5:  r = neg ? '{NEG_LIM / 5, DIGIT_W'(NEG_LIM % 5)}
                           : '{POS_LIM / 5, DIGIT_W'(POS_LIM % 5)};
            6'd6:  r = neg ? '{NEG_LIM / 6, DIGIT_W'(NEG_LIM % 6)}
                           : '{POS_LIM / 6, DIGIT_W'(POS_LIM % 6)};
            6'd7:  r = neg ? '{NEG_LIM / 7, DIGIT_W'(NEG_LIM % 7)}
                           : '{POS_LIM / 7, DIGIT_W'(POS_LIM % 7)};
            6'd8:  r = neg ? '{NEG_LIM / 8, DIGIT_W'(NEG_LIM % 8)}
                           : '{POS_LIM / 8, DIGIT_W'(POS_LIM % 8)};
            6'd9:  r = neg ? '{NEG_LIM / 9, DIGIT_W'(NEG_LIM % 9)}
                           : '{POS_LIM / 9, DIGIT_W'(POS_LIM % 9)};
            6'd10: r = neg ? '{NEG_LIM / 10, DIGIT_W'(NEG_LIM % 10)}
                           : '{POS_LIM / 10, DIGIT_W'(POS_LIM % 10)};
            6'd11: r = neg ? '{NEG_LIM / 11, DIGIT_W'(NEG_LIM % 11)}
                           : '{POS_LIM / 11, DIGIT_W'(POS_LIM % 11)};
            6'd12: r = neg ? '{NEG_LIM / 12, DIGIT_W'(NEG_LIM % 12)}
                           : '{POS_LIM / 12, DIGIT_W'(POS_LIM % 12)};
            6'd13: r = neg ? '{NEG_LIM / 13, DIGIT_W'(NEG_LIM % 13)}
                           : '{POS_LIM / 13, DIGIT_W'(POS_LIM % 13)};
            6'd14: r = neg ? '{NEG_LIM / 14, DIGIT_W'(NEG_LIM % 14)}
                           : '{POS_LIM / 14, DIGIT_W'(POS_LIM % 14)};
            6'd15: r = neg ? '{NEG_LIM / 15, DIGIT_W'(NEG_LIM % 15)}
                           : '{POS_LIM / 15, DIGIT_W'(POS_LIM % 15)};
            6'd16: r = neg ? '{NEG_LIM / 16, DIGIT_W'(NEG_LIM % 16)}
                           : '{POS_LIM / 16, DIGIT_W'(POS_LIM % 16)};
            6'd17: r = neg ? '{NEG_LIM / 17, DIGIT_W'(NEG_LIM % 17)}
                           : '{POS_LIM / 17, DIGIT_W'(POS_LIM % 17)};
            6'd18: r = neg ? '{NEG_LIM / 18, DIGIT_W'(NEG_LIM % 18)}
                           : '{POS_LIM / 18, DIGIT_W'(POS_LIM % 18)};
            6'd19: r = neg ? '{NEG_LIM / 19, DIGIT_W'(NEG_LIM % 19)}
                           : '{POS_LIM / 19, DIGIT_W'(POS_LIM % 19)};
            6'd20: r = neg ? '{NEG_LIM / 20, DIGIT_W'(NEG_LIM % 20)}
                           : '{POS_LIM / 20, DIGIT_W'(POS_LIM % 20)};
            6'd21: r = neg ? '{NEG_LIM / 21, DIGIT_W'(NEG_LIM % 21)}
                           : '{POS_LIM / 21, DIGIT_W'(POS_LIM % 21)};
            6'd22: r = neg ? '{NEG_LIM / 22, DIGIT_W'(NEG_LIM % 22)}
                           : '{POS_LIM / 22, DIGIT_W'(POS_LIM % 22)};
            6'd23: r = neg ? '{NEG_LIM / 23, DIGIT_W'(NEG_LIM % 23)}
                           : '{POS_LIM / 23, DIGIT_W'(POS_LIM % 23)};
            6'd24: r = neg ? '{NEG_LIM / 24, DIGIT_W'(NEG_LIM % 24)}
                           : '{POS_LIM / 24, DIGIT_W'(POS_LIM % 24)};
            6'd25: r = neg ? '{NEG_LIM / 25, DIGIT_W'(NEG_LIM % 25)}
                           : '{POS_LIM / 25, DIGIT_W'(POS_LIM % 25)};
            6'd26: r = neg ? '{NEG_LIM / 26, DIGIT_W'(NEG_LIM % 26)}
                           : '{POS_LIM / 26, DIGIT_W'(POS_LIM % 26)};
            6'd27: r = neg ? '{NEG_LIM / 27, DIGIT_W'(NEG_LIM % 27)}
                           : '{POS_LIM / 27, DIGIT_W'(POS_LIM % 27)};
            6'd28: r = neg ? '{NEG_LIM / 28, DIGIT_W'(NEG_LIM % 28)}
                           : '{POS_LIM / 28, DIGIT_W'(POS_LIM % 28)};
            6'd29: r = neg ? '{NEG_LIM / 29, DIGIT_W'(NEG_LIM % 29)}
                           : '{POS_LIM / 29, DIGIT_W'(POS_LIM % 29)};
            6'd30: r = neg ? '{NEG_LIM / 30, DIGIT_W'(NEG_LIM % 30)}
                           : '{POS_LIM / 30, DIGIT_W'(POS_LIM % 30)};
            6'd31: r = neg ? '{NEG_LIM / 31, DIGIT_W'(NEG_LIM % 31)}
                           : '{POS_LIM / 31, DIGIT_W'(POS_LIM % 31)};
            6'd32: r = neg ? '{NEG_LIM / 32, DIGIT_W'(NEG_LIM % 32)}
                           : '{POS_LIM / 32, DIGIT_W'(POS_LIM % 32)};
            6'd33: r = neg ? '{NEG_LIM / 33, DIGIT_W'(NEG_LIM % 33)}
                           : '{POS_LIM / 33, DIGIT_W'(POS_LIM % 33)};
            6'd34: r = neg ? '{NEG_LIM / 34, DIGIT_W'(NEG_LIM % 34)}
                           : '{POS_LIM / 34, DIGIT_W'(POS_LIM % 34)};
            6'd35: r = neg ? '{NEG_LIM / 35, DIGIT_W'(NEG_LIM % 35)}
                           : '{POS_LIM / 35, DIGIT_W'(POS_LIM % 35)};
            6'd36: r = neg ? '{NEG_LIM / 36, DIGIT_W'(NEG_LIM % 36)}
                           : '{POS_LIM / 36, DIGIT_W'(POS_LIM % 36)};
            default: r = '{cut: '0, last: '0};
        endcase
        return r;
    endfunction

endpackage

// ===== design/ttip_char_if.sv =====
`timescale 1ns / 1ps

interface ttip_char_if;
    logic                         valid;
    logic                         ready;
    logic [ttip_pkg::CHAR_W-1:0]  text_char;

    modport source (output valid, output text_char, input ready);
    modport sink   (input valid, input text_char, output ready);
endinterface

// ===== design/ttip_result_if.sv =====
`timescale 1ns / 1ps

interface ttip_result_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [ttip_pkg::VALUE_WIDTH-1:0]   parsed_value;
    logic                                      range_overflow;
    logic                                      digits_found;
    logic        [ttip_pkg::LENGTH_WIDTH-1:0]  consumed_length;

    modport source (output valid, output parsed_value, output range_overflow,
                    output digits_found, output consumed_length, input ready);
    modport sink   (input valid, input parsed_value, input range_overflow,
                    input digits_found, input consumed_length, output ready);
endinterface

// ===== design/ttip_cfg_if.sv =====
`timescale 1ns / 1ps

interface ttip_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [ttip_pkg::BASE_W-1:0]  number_base;

    modport source (output valid, output number_base, input ready);
    modport sink   (input valid, input number_base, output ready);
endinterface

// ===== design/ttip_ctrl.sv =====
`timescale 1ns / 1ps

module ttip_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ttip_pkg::status_t  status,
    output ttip_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_BODY,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    phase_t state_reg;
    phase_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    ttip_pkg::op_t op;
    ttip_pkg::op_t start_op;
    phase_t        start_phase;

    // Take a request whenever the result register is free or draining
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign cmd.op    = op;

    // Decide how the first byte of a number body is handled
    always_comb
    begin
        if (status.cfg_invalid)
        begin
            start_op    = ttip_pkg::OP_FINISH;
            start_phase = PH_SKIP;
        end
        else if (status.prefix_ok && status.is_zero_char)
        begin
            start_op    = ttip_pkg::OP_ZERO_PREFIX;
            start_phase = PH_ZERO;
        end
        else if (status.start_digit_ok)
        begin
            start_op    = ttip_pkg::OP_START_DIGIT;
            start_phase = PH_DIGITS;
        end
        else
        begin
            start_op    = ttip_pkg::OP_FINISH;
            start_phase = PH_SKIP;
        end
    end

    // Advance the parse phase on each accepted byte
    always_comb
    begin
        op         = ttip_pkg::OP_NONE;
        state_next = state_reg;
        if (accept)
        begin
            case (state_reg)
                PH_SKIP:
                begin
                    if (status.is_white)
                    begin
                        op = ttip_pkg::OP_COUNT;
                    end
                    else if (status.is_sign)
                    begin
                        op         = ttip_pkg::OP_SIGN;
                        state_next = PH_BODY;
                    end
                    else
                    begin
                        op         = start_op;
                        state_next = start_phase;
                    end
                end
                PH_BODY:
                begin
                    op         = start_op;
                    state_next = start_phase;
                end
                PH_ZERO:
                begin
                    if (status.is_hex_mark)
                    begin
                        op         = ttip_pkg::OP_HEX;
                        state_next = PH_DIGITS;
                    end
                    else if (status.digit_ok)
                    begin
                        op         = ttip_pkg::OP_DIGIT;
                        state_next = PH_DIGITS;
                    end
                    else
                    begin
                        op         = ttip_pkg::OP_FINISH;
                        state_next = PH_SKIP;
                    end
                end
                PH_DIGITS:
                begin
                    if (status.digit_ok)
                    begin
                        op = ttip_pkg::OP_DIGIT;
                    end
                    else
                    begin
                        op         = ttip_pkg::OP_FINISH;
                        state_next = PH_SKIP;
                    end
                end
                default:
                begin
                    op         = ttip_pkg::OP_NONE;
                    state_next = PH_SKIP;
                end
            endcase
        end
    end

    // Hold the result valid until the receiver takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (op == ttip_pkg::OP_FINISH)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PH_SKIP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/ttip_datapath.sv =====
`timescale 1ns / 1ps

module ttip_datapath (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic [ttip_pkg::CHAR_W-1:0]              text_char,
    input  logic                                     cfg_we,
    input  logic [ttip_pkg::BASE_W-1:0]              cfg_base,
    input  ttip_pkg::cmd_t                           cmd,
    output ttip_pkg::status_t                        status,
    output logic signed [ttip_pkg::VALUE_WIDTH-1:0]  parsed_value,
    output logic                                     range_overflow,
    output logic                                     digits_found,
    output logic [ttip_pkg::LENGTH_WIDTH-1:0]        consumed_length
);

    logic [ttip_pkg::BASE_W-1:0]       base_cfg_reg;
    logic                              neg_reg;
    logic                              neg_next;
    logic [ttip_pkg::VALUE_WIDTH-1:0]  acc_reg;
    logic [ttip_pkg::VALUE_WIDTH-1:0]  acc_next;
    logic                              ovf_reg;
    logic                              ovf_next;
    logic                              any_reg;
    logic                              any_next;
    logic [ttip_pkg::BASE_W-1:0]       base_reg;
    logic [ttip_pkg::BASE_W-1:0]       base_next;
    ttip_pkg::cutoff_t                 cut_reg;
    ttip_pkg::cutoff_t                 cut_next;
    logic [ttip_pkg::LENGTH_WIDTH-1:0] pos_reg;
    logic [ttip_pkg::LENGTH_WIDTH-1:0] pos_next;

    logic signed [ttip_pkg::VALUE_WIDTH-1:0] value_reg;
    logic signed [ttip_pkg::VALUE_WIDTH-1:0] value_next;
    logic                              res_ovf_reg;
    logic                              res_any_reg;
    logic [ttip_pkg::LENGTH_WIDTH-1:0] res_len_reg;
    logic [ttip_pkg::LENGTH_WIDTH-1:0] res_len_next;

    logic                              dvalid;
    logic [ttip_pkg::DIGIT_W-1:0]      digit;
    logic [ttip_pkg::BASE_W-1:0]       start_base;
    logic [ttip_pkg::BASE_W-1:0]       lookup_base;
    ttip_pkg::cutoff_t                 lookup_cut;
    logic                              over_limit;
    logic [ttip_pkg::VALUE_WIDTH-1:0]  acc_scaled;
    logic [ttip_pkg::LENGTH_WIDTH-1:0] pos_inc;

    // Decode the byte into a digit value
    always_comb
    begin
        dvalid = 1'b1;
        digit  = '0;
        if (text_char >= ttip_pkg::CH_ZERO && text_char <= ttip_pkg::CH_NINE)
        begin
            digit = ttip_pkg::DIGIT_W'(text_char - ttip_pkg::CH_ZERO);
        end
        else if (text_char >= ttip_pkg::CH_UA && text_char <= ttip_pkg::CH_UZ)
        begin
            digit = ttip_pkg::DIGIT_W'(text_char - ttip_pkg::UPPER_OFS);
        end
        else if (text_char >= ttip_pkg::CH_LA && text_char <= ttip_pkg::CH_LZ)
        begin
            digit = ttip_pkg::DIGIT_W'(text_char - ttip_pkg::LOWER_OFS);
        end
        else
        begin
            dvalid = 1'b0;
        end
    end

    // Classify the byte for the controller
    assign start_base = (base_cfg_reg == ttip_pkg::BASE_AUTO) ? ttip_pkg::BASE_DEC
                                                              : base_cfg_reg;

    assign status.is_white = (text_char == ttip_pkg::CH_SPACE) ||
                             (text_char >= ttip_pkg::CH_TAB && text_char <= ttip_pkg::CH_CR);
    assign status.is_sign = (text_char == ttip_pkg::CH_PLUS) ||
                            (text_char == ttip_pkg::CH_MINUS);
    assign status.is_zero_char = (text_char == ttip_pkg::CH_ZERO);
    assign status.is_hex_mark = (text_char == ttip_pkg::CH_LX) ||
                                (text_char == ttip_pkg::CH_UX);
    assign status.cfg_invalid = (base_cfg_reg == ttip_pkg::BASE_ONE) ||
                                (base_cfg_reg > ttip_pkg::BASE_MAX);
    assign status.prefix_ok = (base_cfg_reg == ttip_pkg::BASE_AUTO) ||
                              (base_cfg_reg == ttip_pkg::BASE_HEX);
    assign status.start_digit_ok = dvalid && (digit < start_base);
    assign status.digit_ok = dvalid && (base_reg >= 6'd2) && (digit < base_reg);

    // Look up the limit for the radix being latched
    always_comb
    begin
        case (cmd.op)
            ttip_pkg::OP_HEX:
            begin
                lookup_base = ttip_pkg::BASE_HEX;
            end
            ttip_pkg::OP_ZERO_PREFIX:
            begin
                lookup_base = (base_cfg_reg == ttip_pkg::BASE_AUTO) ? ttip_pkg::BASE_OCT
                                                                    : ttip_pkg::BASE_HEX;
            end
            default:
            begin
                lookup_base = start_base;
            end
        endcase
    end

    assign lookup_cut = ttip_pkg::cutoff_lookup(lookup_base, neg_reg);

    // Accumulate one digit with the overflow check
    assign over_limit = (acc_reg > cut_reg.cut) ||
                        ((acc_reg == cut_reg.cut) && (digit > cut_reg.last));
    assign acc_scaled = acc_reg * ttip_pkg::VALUE_WIDTH'(base_reg) +
                        ttip_pkg::VALUE_WIDTH'(digit);
    assign pos_inc = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;

    // Form the final value of the number
    always_comb
    begin
        if (!any_reg)
        begin
            value_next = '0;
        end
        else if (ovf_reg)
        begin
            value_next = neg_reg ? $signed(ttip_pkg::NEG_LIM) : $signed(ttip_pkg::POS_LIM);
        end
        else if (neg_reg)
        begin
            value_next = $signed('0 - acc_reg);
        end
        else
        begin
            value_next = $signed(acc_reg);
        end
        res_len_next = any_reg ? pos_reg : '0;
    end

    // Update the number state for the issued operation
    always_comb
    begin
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        any_next  = any_reg;
        base_next = base_reg;
        cut_next  = cut_reg;
        pos_next  = pos_reg;
        case (cmd.op)
            ttip_pkg::OP_NONE:
            begin
                pos_next = pos_reg;
            end
            ttip_pkg::OP_COUNT:
            begin
                pos_next = pos_inc;
            end
            ttip_pkg::OP_SIGN:
            begin
                neg_next = (text_char == ttip_pkg::CH_MINUS);
                pos_next = pos_inc;
            end
            ttip_pkg::OP_ZERO_PREFIX:
            begin
                base_next = lookup_base;
                cut_next  = lookup_cut;
                acc_next  = '0;
                any_next  = 1'b1;
                pos_next  = pos_inc;
            end
            ttip_pkg::OP_START_DIGIT:
            begin
                base_next = lookup_base;
                cut_next  = lookup_cut;
                acc_next  = ttip_pkg::VALUE_WIDTH'(digit);
                any_next  = 1'b1;
                pos_next  = pos_inc;
            end
            ttip_pkg::OP_HEX:
            begin
                base_next = lookup_base;
                cut_next  = lookup_cut;
                any_next  = 1'b0;
                pos_next  = pos_inc;
            end
            ttip_pkg::OP_DIGIT:
            begin
                if (ovf_reg || over_limit)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    acc_next = acc_scaled;
                end
                any_next = 1'b1;
                pos_next = pos_inc;
            end
            ttip_pkg::OP_FINISH:
            begin
                neg_next  = 1'b0;
                acc_next  = '0;
                ovf_next  = 1'b0;
                any_next  = 1'b0;
                base_next = '0;
                cut_next  = '{cut: '0, last: '0};
                pos_next  = '0;
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    // Hold the radix register and the number state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_cfg_reg <= ttip_pkg::BASE_RESET;
            neg_reg      <= 1'b0;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
            any_reg      <= 1'b0;
            base_reg     <= '0;
            cut_reg      <= '{cut: '0, last: '0};
            pos_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_cfg_reg <= cfg_base;
            end
            neg_reg  <= neg_next;
            acc_reg  <= acc_next;
            ovf_reg  <= ovf_next;
            any_reg  <= any_next;
            base_reg <= base_next;
            cut_reg  <= cut_next;
            pos_reg  <= pos_next;
        end
    end

    // Load the result register when a number ends
    always_ff @(posedge clk)
    begin
        if (cmd.op == ttip_pkg::OP_FINISH)
        begin
            value_reg   <= value_next;
            res_ovf_reg <= ovf_reg;
            res_any_reg <= any_reg;
            res_len_reg <= res_len_next;
        end
    end

    assign parsed_value    = value_reg;
    assign range_overflow  = res_ovf_reg;
    assign digits_found    = res_any_reg;
    assign consumed_length = res_len_reg;

endmodule

// ===== design/text_to_integer_parser.sv =====
`timescale 1ns / 1ps

// Streaming text-to-integer parser with strtol semantics.
// chars:   one text byte per request (valid/ready); a byte is taken when
//          both are high.
// results: one request per parsed number, carrying the value, overflow
//          flag, digits-found flag and consumed length.
// cfg:     radix register write (valid/ready); ready is always high.
//          Write it only between numbers; it is sampled at the first byte
//          of each number body.
// Throughput: one byte per cycle unless stalled. Each byte is handled in
// the cycle it is taken, with one digit multiply-add of the accumulator
// per cycle. Output: results is valid in the cycle after the byte that
// ends the number is taken. Bytes that do not end a number give nothing.
// Stall: the result register holds one number; while it waits on a low
// results.ready, chars.ready drops; ready follows results.ready when full.
// Reset: radix returns to 10, the parser returns to skipping white space
// and no result is pending.
module text_to_integer_parser (
    input logic           clk,
    input logic           rst_n,
    ttip_char_if.sink     chars,
    ttip_result_if.source results,
    ttip_cfg_if.sink      cfg
);

    ttip_pkg::cmd_t    cmd;
    ttip_pkg::status_t status;

    assign cfg.ready = 1'b1;

    ttip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chars.valid),
        .in_ready  (chars.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    ttip_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .text_char       (chars.text_char),
        .cfg_we          (cfg.valid),
        .cfg_base        (cfg.number_base),
        .cmd             (cmd),
        .status          (status),
        .parsed_value    (results.parsed_value),
        .range_overflow  (results.range_overflow),
        .digits_found    (results.digits_found),
        .consumed_length (results.consumed_length)
    );

    // A new result only follows a taken byte
    a_result_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(chars.valid && chars.ready))
        else $error("result appeared without a taken byte");

    // Overflow only on a number that had digits
    a_ovf_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.range_overflow) |-> results.digits_found)
        else $error("overflow flagged without digits");

    // No conversion gives a zero value and zero length
    a_no_conv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.digits_found) |->
        (results.parsed_value == 0 && results.consumed_length == 0))
        else $error("no conversion with nonzero fields");

    // Input stalls while a result is held back
    a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.ready) |-> !chars.ready)
        else $error("byte taken while result stalled");

endmodule

// ===== test/ttip_parse_checker.sv =====
`timescale 1ns / 1ps

// Watches the text, result and radix channels of the parser, tracks the
// parse of every accepted character and compares each result request
// against the oldest predicted number.
module ttip_parse_checker (
    input  logic    clk,
    input  logic    rst_n,
    ttip_char_if    chars,
    ttip_result_if  results,
    ttip_cfg_if     cfg,
    output int      errors,
    output int      pending
);

    import ttip_pkg::*;

    localparam logic [CHAR_W-1:0] NO_DIGIT = 8'hFF;

    typedef enum logic [1:0] {
        SCAN_BLANKS,
        AWAIT_BODY,
        AFTER_LEAD_ZERO,
        IN_DIGITS
    } scan_e;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          overflow;
        logic                          found;
        logic [LENGTH_WIDTH-1:0]       length;
    } parse_result_t;

    // Radix register copy and per-number parse state
    logic [BASE_W-1:0]       radix_reg;
    logic [BASE_W-1:0]       radix_used;
    scan_e                   scan;
    logic                    minus;
    logic [63:0]             acc;
    logic [63:0]             acc_cut;
    logic [63:0]             last_cut;
    logic                    sat;
    logic                    got_digit;
    logic [LENGTH_WIDTH-1:0] count;

    parse_result_t           expected_numbers[$];
    parse_result_t           want;
    parse_result_t           made;
    logic                    closed;

    function automatic logic [63:0] magnitude_limit(input logic n);
        return (64'd1 << (VALUE_WIDTH - 1)) - (n ? 64'd0 : 64'd1);
    endfunction

    function automatic logic [CHAR_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return c - CH_ZERO;
        if (c >= CH_UA && c <= CH_UZ)
            return c - UPPER_OFS;
        if (c >= CH_LA && c <= CH_LZ)
            return c - LOWER_OFS;
        return NO_DIGIT;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    task automatic clear_number();
        scan       = SCAN_BLANKS;
        minus      = 1'b0;
        acc        = '0;
        sat        = 1'b0;
        got_digit  = 1'b0;
        radix_used = '0;
        acc_cut    = '0;
        last_cut   = '0;
        count      = '0;
    endtask

    task automatic bump_count();
        if (count != '1)
            count++;
    endtask

    // Latch the radix and its overflow limits for the current sign
    task automatic load_radix(input logic [BASE_W-1:0] b);
        logic [63:0] lim;
        lim        = magnitude_limit(minus);
        radix_used = b;
        acc_cut    = lim / b;
        last_cut   = lim % b;
    endtask

    // Build the result of the number that just ended, then start over
    task automatic close_number(output parse_result_t r);
        logic [63:0] v;
        if (sat)
            v = magnitude_limit(minus);
        else if (minus)
            v = 64'd0 - acc;
        else
            v = acc;
        if (!got_digit)
            v = '0;
        r.value    = v[VALUE_WIDTH-1:0];
        r.overflow = sat;
        r.found    = got_digit;
        r.length   = got_digit ? count : '0;
        clear_number();
    endtask

    task automatic take_digit(input logic [CHAR_W-1:0] c, output logic done,
                              output parse_result_t r);
        logic [CHAR_W-1:0] d;
        d    = digit_value(c);
        done = 1'b0;
        r    = '0;
        if (radix_used < 2 || d >= radix_used) begin
            close_number(r);
            done = 1'b1;
        end
        else begin
            if (sat || acc > acc_cut || (acc == acc_cut && d > last_cut))
                sat = 1'b1;
            else
                acc = acc * radix_used + d;
            got_digit = 1'b1;
            bump_count();
            scan = IN_DIGITS;
        end
    endtask

    // First character after blanks and sign: sample the radix register here
    task automatic start_body(input logic [CHAR_W-1:0] c, output logic done,
                              output parse_result_t r);
        logic [BASE_W-1:0] b;
        b    = radix_reg;
        done = 1'b0;
        r    = '0;
        if (b == BASE_ONE || b > BASE_MAX) begin
            radix_used = '0;
            close_number(r);
            done = 1'b1;
        end
        else if ((b == BASE_AUTO || b == BASE_HEX) && c == CH_ZERO) begin
            load_radix(b == BASE_AUTO ? BASE_OCT : BASE_HEX);
            acc       = '0;
            got_digit = 1'b1;
            bump_count();
            scan = AFTER_LEAD_ZERO;
        end
        else begin
            load_radix(b == BASE_AUTO ? BASE_DEC : b);
            take_digit(c, done, r);
        end
    endtask

    task automatic predict_char(input logic [CHAR_W-1:0] c, output logic done,
                                output parse_result_t r);
        done = 1'b0;
        r    = '0;
        case (scan)
            SCAN_BLANKS:
            begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                    bump_count();
                end
                else if (c == CH_MINUS || c == CH_PLUS) begin
                    minus = (c == CH_MINUS);
                    bump_count();
                    scan = AWAIT_BODY;
                end
                else begin
                    start_body(c, done, r);
                end
            end
            AWAIT_BODY:
            begin
                start_body(c, done, r);
            end
            AFTER_LEAD_ZERO:
            begin
                if (c == CH_LX || c == CH_UX) begin
                    load_radix(BASE_HEX);
                    got_digit = 1'b0;
                    bump_count();
                    scan = IN_DIGITS;
                end
                else begin
                    take_digit(c, done, r);
                end
            end
            default:
            begin
                take_digit(c, done, r);
            end
        endcase
    endtask

    // Check result requests first, then advance the prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            radix_reg = BASE_RESET;
            clear_number();
            expected_numbers.delete();
            errors  = 0;
            pending = 0;
        end
        else begin
            if (results.valid && results.ready) begin
                if (expected_numbers.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected result value=%0d ovf=%0b found=%0b len=%0d",
                        results.parsed_value, results.range_overflow,
                        results.digits_found, results.consumed_length));
                end
                else begin
                    want = expected_numbers.pop_front();
                    if (results.parsed_value !== want.value)
                        report_mismatch($sformatf("parsed_value got %0d expected %0d",
                            results.parsed_value, want.value));
                    if (results.range_overflow !== want.overflow)
                        report_mismatch($sformatf("range_overflow got %0b expected %0b",
                            results.range_overflow, want.overflow));
                    if (results.digits_found !== want.found)
                        report_mismatch($sformatf("digits_found got %0b expected %0b",
                            results.digits_found, want.found));
                    if (results.consumed_length !== want.length)
                        report_mismatch($sformatf("consumed_length got %0d expected %0d",
                            results.consumed_length, want.length));
                end
            end
            if (cfg.valid && cfg.ready)
                radix_reg = cfg.number_base;
            if (chars.valid && chars.ready) begin
                predict_char(chars.text_char, closed, made);
                if (closed)
                    expected_numbers.push_back(made);
            end
            pending = expected_numbers.size();
        end
    end

endmodule

// ===== test/text_to_integer_parser_tb.sv =====
`timescale 1ns / 1ps

module text_to_integer_parser_tb;

    import ttip_pkg::*;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   send_mode;
    int   hold_request;
    int   sent_chars;

    // Radix of the first random phases: extremes first, then random picks
    logic [BASE_W-1:0] fixed_radix [9] = '{BASE_AUTO, BASE_HEX, BASE_DEC, BASE_MAX,
                                          BASE_OCT, '1, BASE_MAX + 6'd1, 6'd2, BASE_ONE};

    ttip_char_if   chars ();
    ttip_result_if results ();
    ttip_cfg_if    cfg ();

    text_to_integer_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .results (results),
        .cfg     (cfg)
    );

    ttip_parse_checker parse_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .results (results),
        .cfg     (cfg),
        .errors  (errors),
        .pending (pending)
    );

    initial clk = 1'b0;

    always #1 clk = ~clk;

    // Bound the run in case the block hangs
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // 0: no idling, 1: occasional idling, 2: a random idle every time
    function automatic int draw_wait(input int mode);
        case (mode)
            0:       return 0;
            1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
            default: return $urandom_range(0, 13);
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input int d);
        if (d < 10)
            return CH_ZERO + CHAR_W'(d);
        return ($urandom_range(0, 1) ? CH_UA : CH_LA) + CHAR_W'(d - 10);
    endfunction

    function automatic logic [CHAR_W-1:0] blank_char();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB + CHAR_W'($urandom_range(0, 4));
    endfunction

    // Offer one character and hold it until the parser takes it
    task automatic push_char(input logic [CHAR_W-1:0] c);
        int gap;
        gap = draw_wait(send_mode);
        @(negedge clk);
        if (gap > 0) begin
            chars.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        chars.valid     = 1'b1;
        chars.text_char = c;
        do @(posedge clk); while (chars.ready !== 1'b1);
        sent_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    // Drop the text stream, wait for every result, then write the radix
    task automatic drain_and_write(input logic [BASE_W-1:0] b);
        @(negedge clk);
        chars.valid = 1'b0;
        wait (pending == 0);
        repeat (3) @(negedge clk);
        cfg.valid       = 1'b1;
        cfg.number_base = b;
        do @(posedge clk); while (cfg.ready !== 1'b1);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic emit_magnitude(input longint unsigned m, input int b);
        logic [CHAR_W-1:0] digs[$];
        do begin
            digs.push_front(digit_char(int'(m % b)));
            m = m / b;
        end while (m != 0);
        foreach (digs[i])
            push_char(digs[i]);
    endtask

    // End a number with some byte the parser will not accept as a digit
    task automatic send_terminator(input int eb);
        case ($urandom_range(0, 6))
            0: push_char(blank_char());
            1: push_char('0);
            2: push_char(CHAR_W'($urandom_range(128, 255)));
            3: push_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            4: push_char(CHAR_W'($urandom_range(33, 47)));
            default:
            begin
                if (eb >= 2 && eb < BASE_MAX)
                    push_char(digit_char(eb));
                else
                    push_char(CH_SPACE);
            end
        endcase
    endtask

    // Blanks, sign, optional prefix, digits in the active radix, terminator
    task automatic send_number(input logic [BASE_W-1:0] radix);
        int              eb;
        int              pick;
        logic            neg;
        logic [63:0]     lim;
        longint unsigned mag;
        if ($urandom_range(0, 1))
            repeat ($urandom_range(1, 3)) push_char(blank_char());
        pick = $urandom_range(0, 2);
        neg  = (pick == 2);
        if (pick == 1)
            push_char(CH_PLUS);
        else if (neg)
            push_char(CH_MINUS);
        eb = (radix == BASE_AUTO || radix == BASE_ONE || radix > BASE_MAX) ? BASE_DEC : radix;
        if (radix == BASE_AUTO || radix == BASE_HEX) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) begin
                push_char(CH_ZERO);
                push_char($urandom_range(0, 1) ? CH_LX : CH_UX);
                eb = BASE_HEX;
                // bare prefix with no hex digit
                if ($urandom_range(0, 5) == 0) begin
                    send_terminator(eb);
                    return;
                end
            end
            else if (pick == 1 && radix == BASE_AUTO) begin
                push_char(CH_ZERO);
                eb = BASE_OCT;
            end
        end
        lim = (64'd1 << (VALUE_WIDTH - 1)) - (neg ? 64'd0 : 64'd1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: mag = $urandom_range(0, 300);
            4, 5:       mag = $urandom;
            6, 7:       mag = lim + $urandom_range(0, 4) - 2;
            8:          mag = {$urandom, $urandom};
            default:
            begin
                repeat ($urandom_range(1, 3)) push_char(CH_ZERO);
                mag = $urandom_range(0, 99);
            end
        endcase
        emit_magnitude(mag, eb);
        send_terminator(eb);
    endtask

    // One radix setting: mostly well-formed numbers, some raw noise
    task automatic run_phase(input logic [BASE_W-1:0] b, input int budget, input int mode);
        int start;
        drain_and_write(b);
        send_mode = mode;
        start     = sent_chars;
        while (sent_chars - start < budget) begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 6)) push_char(CHAR_W'($urandom_range(0, 255)));
            else
                send_number(b);
        end
        // leave a number open across the next radix write
        if ($urandom_range(0, 2) == 0) begin
            push_char(CH_MINUS);
            push_char(digit_char(1));
        end
    endtask

    // Result side: random stalls per request, plus long hold-offs on demand
    initial
    begin
        int stall;
        int mode;
        int served;
        int hold;
        results.ready = 1'b0;
        mode          = 0;
        served        = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (served % 40 == 0)
                mode = $urandom_range(0, 2);
            if (hold_request > 0) begin
                hold          = hold_request;
                hold_request  = 0;
                results.ready = 1'b0;
                repeat (hold) @(negedge clk);
            end
            stall = draw_wait(mode);
            if (stall > 0) begin
                results.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            results.ready = 1'b1;
            do @(posedge clk); while (results.valid !== 1'b1);
            served++;
        end
    end

    // Text stimulus and verdict
    initial
    begin
        int                start_random;
        int                phase;
        logic [BASE_W-1:0] b;
        rst_n           = 1'b0;
        chars.valid     = 1'b0;
        chars.text_char = '0;
        cfg.valid       = 1'b0;
        cfg.number_base = '0;
        send_mode       = 0;
        hold_request    = 0;
        sent_chars      = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset radix: sign, high byte, sign with no digits, NUL, letter past radix
        send_text(" -12");
        push_char(8'hFF);
        push_char(CH_PLUS);
        push_char(8'h00);
        send_text("9z");

        // Auto radix: bare prefix, hex, octal, then a number left open
        drain_and_write(BASE_AUTO);
        send_text("0xg0X1f 0178-7");

        // Open number keeps its latched radix; the next one sees an invalid radix
        drain_and_write(BASE_ONE);
        send_text("3 5");

        start_random = sent_chars;
        phase        = 0;
        while (sent_chars - start_random < 1550) begin
            if (phase < 9)
                b = fixed_radix[phase];
            else if ($urandom_range(0, 9) < 8)
                b = BASE_W'($urandom_range(2, 36));
            else
                b = BASE_W'($urandom_range(0, 63));
            // hold off the result side while text keeps coming at full rate
            if (phase == 2) begin
                hold_request = 400;
                run_phase(b, 130, 0);
            end
            else begin
                run_phase(b, 130, $urandom_range(0, 2));
            end
            phase++;
        end

        @(negedge clk);
        chars.valid = 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
